FILE: rtl/core/xrmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrmc_pkg
// Types, constants and helpers shared by the xor-rotate map checksum block.
// ----------------------------------------------------------------------------
package xrmc_pkg;

  localparam logic [31:0] SEED_CONST  = 32'h03F1379E;
  localparam int          ROT_AMOUNT  = 3;
  localparam int          QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_DATA    = 2'd0;
  localparam logic [1:0] MODE_END     = 2'd1;
  localparam logic [1:0] MODE_CLOSE   = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [1:0] OP_BASE    = 2'd0;
  localparam logic [1:0] OP_INT     = 2'd1;
  localparam logic [1:0] OP_CLOSE   = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       internal_file;
  } in_t;

  typedef struct packed {
    logic [31:0] file_hash;
    logic [31:0] map_checksum;
  } out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] hash;
  } cmd_t;

  function automatic logic [31:0] rotl3(input logic [31:0] x);
    rotl3 = {x[31-ROT_AMOUNT:0], x[31:32-ROT_AMOUNT]};
  endfunction

endpackage

FILE: rtl/core/xor_rotate_map_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_rotate_map_checksum
// Streaming xor-rotate file hash folded into a running map checksum.
// ----------------------------------------------------------------------------
// Input requests (in_valid/in_ready, in_data) carry one byte or one control
// event: file end, close of the base group, or restart. Data bytes without
// the last mark give no result; every file end and every close gives one
// result (file_hash, map_checksum) on out_valid/out_ready. Restart gives none.
// Throughput is one request per cycle while the command queue is not full.
// An accepted request writes its command into the command queue; the output
// register loads it from the queue head once that register is empty or is
// being read. The front part keeps the file hash and folds leftover bytes in
// the accepting cycle; the back part owns the map checksum.
// When the receiver stalls, the result holds in the output register and the
// command queue (QUEUE_DEPTH entries) fills; in_ready drops only while that
// queue is full. Synchronous reset clears hash, checksum, queue and out_valid.
// ----------------------------------------------------------------------------
module xor_rotate_map_checksum #(
  parameter int QUEUE_DEPTH = xrmc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  xrmc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output xrmc_pkg::out_t  out_data
);

  logic           q_full, q_push, q_pop, q_not_empty;
  xrmc_pkg::cmd_t q_cmd, q_head;

  xrmc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  xrmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  xrmc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: rtl/core/xrmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrmc_front
// Accepts requests, builds the per-file hash and issues checksum commands.
// ----------------------------------------------------------------------------
module xrmc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  xrmc_pkg::in_t    in_data,
  input  logic             q_full,
  output logic             q_push,
  output xrmc_pkg::cmd_t   q_cmd
);

  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [23:0] p;
    logic [1:0]  c;
    logic [31:0] h;
    logic        end_file;
    p        = pend_r;
    c        = cnt_r;
    h        = hash_r;
    end_file = 1'b0;
    q_push   = 1'b0;
    q_cmd.op = xrmc_pkg::OP_CLOSE;
    q_cmd.hash = '0;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    hash_nxt = hash_r;
    case (in_data.mode)
      xrmc_pkg::MODE_DATA: begin
        case (c)
          2'd0: begin
            p[7:0] = in_data.data_byte;
            c = 2'd1;
          end
          2'd1: begin
            p[15:8] = in_data.data_byte;
            c = 2'd2;
          end
          2'd2: begin
            p[23:16] = in_data.data_byte;
            c = 2'd3;
          end
          default: begin
            h = xrmc_pkg::rotl3(h ^ {in_data.data_byte, p});
            p = '0;
            c = 2'd0;
          end
        endcase
        end_file = in_data.last_byte;
      end
      xrmc_pkg::MODE_END: begin
        end_file = 1'b1;
      end
      xrmc_pkg::MODE_CLOSE: begin
        q_push = accept;
      end
      default: begin
        q_push   = accept;
        q_cmd.op = xrmc_pkg::OP_RESTART;
        p = '0;
        c = 2'd0;
        h = '0;
      end
    endcase
    if (end_file) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < c) h = xrmc_pkg::rotl3(h ^ {24'd0, p[8*k +: 8]});
      end
      q_push     = accept;
      q_cmd.op   = in_data.internal_file ? xrmc_pkg::OP_INT : xrmc_pkg::OP_BASE;
      q_cmd.hash = h;
      p = '0;
      c = 2'd0;
      h = '0;
    end
    if (accept) begin
      pend_nxt = p;
      cnt_nxt  = c;
      hash_nxt = h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
      hash_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      hash_r <= hash_nxt;
    end
  end

endmodule

FILE: rtl/core/xrmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrmc_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module xrmc_queue #(
  parameter int DEPTH = xrmc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  xrmc_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output xrmc_pkg::cmd_t  head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xrmc_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/xrmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrmc_back
// Applies queued commands to the map checksum and drives the result register.
// ----------------------------------------------------------------------------
module xrmc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  xrmc_pkg::cmd_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output xrmc_pkg::out_t  out_data
);

  logic [31:0]    csum_r, csum_nxt;
  logic           out_valid_r, out_valid_nxt;
  xrmc_pkg::out_t out_r, out_nxt;
  logic           emit;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    csum_nxt = csum_r;
    out_nxt  = out_r;
    emit     = 1'b0;
    if (q_pop) begin
      case (q_head.op)
        xrmc_pkg::OP_BASE: begin
          csum_nxt = csum_r ^ q_head.hash;
          emit     = 1'b1;
        end
        xrmc_pkg::OP_INT: begin
          csum_nxt = xrmc_pkg::rotl3(csum_r ^ q_head.hash);
          emit     = 1'b1;
        end
        xrmc_pkg::OP_CLOSE: begin
          csum_nxt = xrmc_pkg::rotl3(xrmc_pkg::rotl3(csum_r) ^ xrmc_pkg::SEED_CONST);
          emit     = 1'b1;
        end
        default: begin
          csum_nxt = '0;
        end
      endcase
      if (emit) begin
        out_nxt.file_hash    = q_head.hash;
        out_nxt.map_checksum = csum_nxt;
      end
    end
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      csum_r      <= csum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

FILE: bench/tb_xor_rotate_map_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_rotate_map_checksum
// Self-checking bench for the xor-rotate map checksum block. Directed files,
// group closes and restarts come first. A long hold-off on the result side
// follows, then randomly built maps with noise, random gaps and stalls. Each
// result is checked against a local model of the file hash and map checksum.
// ----------------------------------------------------------------------------
module tb_xor_rotate_map_checksum;

  localparam int ITEM_TARGET = 1850;
  localparam int HOLD_CYCLES = 300;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  xrmc_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  xrmc_pkg::out_t out_data;

  xor_rotate_map_checksum uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  logic [31:0]    file_hash_acc;
  logic [23:0]    tail_bytes;
  logic [1:0]     tail_count;
  logic [31:0]    map_sum;
  xrmc_pkg::out_t map_results_due[$];

  int error_count = 0;
  int sent_count;
  int burst_left;
  int gap_max;
  int ready_pct;
  int run_left = 0;
  int hold_left = 0;
  bit ready_now = 1'b1;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] rot_left3(input logic [31:0] x);
    return (x << 3) | (x >> 29);
  endfunction

  function automatic void close_file_model(input logic is_internal);
    logic [31:0]    h;
    xrmc_pkg::out_t res;
    h = file_hash_acc;
    for (int k = 0; k < tail_count; k++) begin
      h = rot_left3(h ^ {24'd0, tail_bytes[8*k +: 8]});
    end
    if (is_internal) begin
      map_sum = rot_left3(map_sum ^ h);
    end else begin
      map_sum = map_sum ^ h;
    end
    file_hash_acc = '0;
    tail_bytes    = '0;
    tail_count    = '0;
    res.file_hash    = h;
    res.map_checksum = map_sum;
    map_results_due.insert(map_results_due.size(), res);
  endfunction

  function automatic void model_map_checksum(input xrmc_pkg::in_t req);
    xrmc_pkg::out_t res;
    case (req.mode)
      xrmc_pkg::MODE_DATA: begin
        if (tail_count == 2'd3) begin
          file_hash_acc = rot_left3(file_hash_acc ^ {req.data_byte, tail_bytes});
          tail_bytes    = '0;
          tail_count    = '0;
        end else begin
          tail_bytes[8*tail_count +: 8] = req.data_byte;
          tail_count = tail_count + 2'd1;
        end
        if (req.last_byte) begin
          close_file_model(req.internal_file);
        end
      end
      xrmc_pkg::MODE_END: begin
        close_file_model(req.internal_file);
      end
      xrmc_pkg::MODE_CLOSE: begin
        map_sum = rot_left3(map_sum);
        map_sum = rot_left3(map_sum ^ xrmc_pkg::SEED_CONST);
        res.file_hash    = '0;
        res.map_checksum = map_sum;
        map_results_due.insert(map_results_due.size(), res);
      end
      default: begin
        file_hash_acc = '0;
        tail_bytes    = '0;
        tail_count    = '0;
        map_sum       = '0;
      end
    endcase
  endfunction

  // Sender: call at a rising edge; leaves valid high after the handshake.
  task automatic send_request(input logic [1:0] mode, input logic [7:0] data_val,
                              input logic last, input logic is_internal);
    xrmc_pkg::in_t req;
    int            gap;
    bit            taken;
    req.mode          = mode;
    req.data_byte     = data_val;
    req.last_byte     = last;
    req.internal_file = is_internal;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) gap = $urandom_range(0, gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    model_map_checksum(req);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (map_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_file(input int len, input logic is_internal, input bit use_marker);
    logic mark;
    for (int i = 0; i < len; i++) begin
      mark = use_marker && (i == len - 1);
      send_request(xrmc_pkg::MODE_DATA, 8'($urandom_range(0, 255)), mark,
                   mark ? is_internal : 1'($urandom_range(0, 1)));
    end
    if (!use_marker || len == 0) begin
      send_request(xrmc_pkg::MODE_END, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), is_internal);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic int pick_file_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 9);
  endfunction

  task automatic test_file_lengths();
    gap_max   = 3;
    ready_pct = 70;
    send_request(xrmc_pkg::MODE_END, 8'h00, 1'b0, 1'b0);
    send_request(xrmc_pkg::MODE_DATA, 8'hFF, 1'b1, 1'b1);
    send_request(xrmc_pkg::MODE_DATA, 8'h00, 1'b0, 1'b1);
    send_request(xrmc_pkg::MODE_DATA, 8'hFF, 1'b0, 1'b0);
    send_request(xrmc_pkg::MODE_DATA, 8'h80, 1'b0, 1'b1);
    send_request(xrmc_pkg::MODE_DATA, 8'h01, 1'b1, 1'b0);
    repeat (4) send_request(xrmc_pkg::MODE_DATA, 8'hFF, 1'b0, 1'b0);
    send_request(xrmc_pkg::MODE_DATA, 8'hFF, 1'b1, 1'b1);
    // three leftover bytes ended by a file-end request with junk fields
    send_request(xrmc_pkg::MODE_DATA, 8'h12, 1'b0, 1'b1);
    send_request(xrmc_pkg::MODE_DATA, 8'h34, 1'b0, 1'b0);
    send_request(xrmc_pkg::MODE_DATA, 8'h56, 1'b0, 1'b1);
    send_request(xrmc_pkg::MODE_END, 8'hFF, 1'b1, 1'b0);
  endtask

  task automatic test_close_group();
    send_request(xrmc_pkg::MODE_CLOSE, 8'hFF, 1'b1, 1'b1);
    send_request(xrmc_pkg::MODE_CLOSE, 8'h00, 1'b0, 1'b0);
    send_request(xrmc_pkg::MODE_END, 8'h00, 1'b0, 1'b1);
    // close while a file is in progress
    send_request(xrmc_pkg::MODE_DATA, 8'hAB, 1'b0, 1'b0);
    send_request(xrmc_pkg::MODE_CLOSE, 8'h5A, 1'b0, 1'b0);
    send_request(xrmc_pkg::MODE_DATA, 8'hCD, 1'b1, 1'b1);
  endtask

  task automatic test_restart();
    send_request(xrmc_pkg::MODE_DATA, 8'h77, 1'b0, 1'b0);
    send_request(xrmc_pkg::MODE_RESTART, 8'hFF, 1'b1, 1'b1);
    send_request(xrmc_pkg::MODE_END, 8'h00, 1'b0, 1'b0);
    drain_results();
  endtask

  task automatic test_backpressure();
    gap_max      = 0;
    ready_pct    = 100;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 5 == 4) begin
        send_request(xrmc_pkg::MODE_DATA, 8'($urandom_range(0, 255)), 1'b0,
                     1'($urandom_range(0, 1)));
      end else begin
        send_request((i % 3 == 0) ? xrmc_pkg::MODE_CLOSE : xrmc_pkg::MODE_END,
                     8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    drain_results();
  endtask

  task automatic test_random_maps();
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        gap_max   = 0;
        ready_pct = 100;
      end else begin
        gap_max   = $urandom_range(1, 8);
        ready_pct = $urandom_range(30, 95);
      end
      if ($urandom_range(0, 4) != 0) begin
        send_request(xrmc_pkg::MODE_RESTART, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        send_file(pick_file_len(), $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) != 0) begin
        send_request(xrmc_pkg::MODE_CLOSE, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 19) == 0) begin
          send_request(xrmc_pkg::MODE_CLOSE, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        send_file(pick_file_len(), $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Receiver: random ready/stall runs, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_left  = $urandom_range(1, 6);
        ready_now = $urandom_range(0, 99) < ready_pct;
      end
      run_left--;
      out_ready <= ready_now;
    end
  end

  always @(negedge clk) begin
    xrmc_pkg::out_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (map_results_due.size() == 0) begin
        $error("unexpected result: file_hash %h map_checksum %h",
               out_data.file_hash, out_data.map_checksum);
        error_count++;
      end else begin
        exp_res = map_results_due.pop_front();
        if (out_data.file_hash !== exp_res.file_hash) begin
          $error("file_hash: expected %h, got %h", exp_res.file_hash, out_data.file_hash);
          error_count++;
        end
        if (out_data.map_checksum !== exp_res.map_checksum) begin
          $error("map_checksum: expected %h, got %h",
                 exp_res.map_checksum, out_data.map_checksum);
          error_count++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    file_hash_acc = '0;
    tail_bytes    = '0;
    tail_count    = '0;
    map_sum       = '0;
    sent_count    = 0;
    burst_left    = 0;
    gap_max       = 0;
    ready_pct     = 100;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_file_lengths();
    test_close_group();
    test_restart();
    test_backpressure();
    test_random_maps();
    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/xrmc_pkg.sv
rtl/core/xrmc_front.sv
rtl/core/xrmc_queue.sv
rtl/core/xrmc_back.sv
rtl/core/xor_rotate_map_checksum.sv
bench/tb_xor_rotate_map_checksum.sv
